// ===== rtl/lbsp_pkg.sv =====
// Shared constants and types for the LRU buffer slot pool.
`timescale 1ns / 1ps

package lbsp_pkg;

  // Pool geometry
  localparam int SlotCount = 16;
  localparam int TagBits   = 16;
  localparam int SlotIdxW  = (SlotCount > 1) ? $clog2(SlotCount) : 1;

  // Fixed port widths
  localparam int BlockW    = 16;
  localparam int SlotOutW  = 4;

  typedef logic [SlotIdxW-1:0] slot_idx_t;
  typedef logic [TagBits-1:0]  tag_t;

  // Request to move one slot to the most recent end of the order
  typedef struct packed {
    logic      valid;
    slot_idx_t slot;
  } promote_t;

endpackage

// ===== rtl/lbsp_recency.sv =====
// Recency order of the slots: least recent at position 0, most recent at the top.
`timescale 1ns / 1ps

module lbsp_recency (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lbsp_pkg::promote_t         promote_i,
  output lbsp_pkg::slot_idx_t        lru_slot_o
);

  lbsp_pkg::slot_idx_t order_q [lbsp_pkg::SlotCount];
  lbsp_pkg::slot_idx_t order_d [lbsp_pkg::SlotCount];

  logic [lbsp_pkg::SlotCount-1:0] pos_match;
  logic [lbsp_pkg::SlotCount-1:0] at_or_above;

  // Locate the promoted slot in the order
  always_comb begin
    for (int i = 0; i < lbsp_pkg::SlotCount; i++) begin
      pos_match[i] = (order_q[i] == promote_i.slot);
    end
  end

  // Mark every position from the match upward
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < lbsp_pkg::SlotCount; i++) begin
      seen           = seen | pos_match[i];
      at_or_above[i] = seen;
    end
  end

  // Shift entries above the match down by one, put the slot on top
  always_comb begin
    for (int i = 0; i < lbsp_pkg::SlotCount; i++) begin
      order_d[i] = order_q[i];
    end
    if (promote_i.valid) begin
      for (int i = 0; i < lbsp_pkg::SlotCount - 1; i++) begin
        if (at_or_above[i]) begin
          order_d[i] = order_q[i+1];
        end
      end
      order_d[lbsp_pkg::SlotCount-1] = promote_i.slot;
    end
  end

  // Hold the order; reset to ascending slot indices
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lbsp_pkg::SlotCount; i++) begin
        order_q[i] <= lbsp_pkg::SlotIdxW'(i);
      end
    end else begin
      for (int i = 0; i < lbsp_pkg::SlotCount; i++) begin
        order_q[i] <= order_d[i];
      end
    end
  end

  assign lru_slot_o = order_q[0];

endmodule

// ===== rtl/lru_buffer_slot_pool.sv =====
// Top level of the LRU buffer slot pool: tag store, lookup and result register.
// A word accepted with start passes the input register, then lookup and update into the
// result register, which raises the result strobe.
// Throughput: one word per cycle; busy stays low and the receiver cannot stall,
// the tag compare and recency shift are combinational, the state write shares the result edge.
// Reset: all slots invalid, recency order ascending with slot 0 least recent.
`timescale 1ns / 1ps

module lru_buffer_slot_pool (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] block_number_i,
  output logic        done_o,
  output logic        hit_o,
  output logic [3:0]  slot_index_o,
  output logic        evicted_valid_o,
  output logic [15:0] evicted_block_o
);

  // Input register
  logic                req_valid_q;
  lbsp_pkg::tag_t      req_tag_q;

  // Slot store
  lbsp_pkg::tag_t                 slot_tag_q [lbsp_pkg::SlotCount];
  logic [lbsp_pkg::SlotCount-1:0] slot_valid_q;
  logic [lbsp_pkg::SlotCount-1:0] slot_valid_d;

  // Lookup
  logic [lbsp_pkg::SlotCount-1:0] match_vec;
  logic                           any_hit;
  lbsp_pkg::slot_idx_t            hit_slot;
  lbsp_pkg::slot_idx_t            lru_slot;
  lbsp_pkg::slot_idx_t            sel_slot;
  logic                           ev_valid;
  lbsp_pkg::tag_t                 ev_tag;
  lbsp_pkg::promote_t             promote;

  // Result register
  logic                           done_q;
  logic                           hit_q;
  lbsp_pkg::slot_idx_t            slot_q;
  logic                           ev_valid_q;
  lbsp_pkg::tag_t                 ev_tag_q;

  // Never stall the requester
  assign busy = 1'b0;

  // Capture the request word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_tag_q <= lbsp_pkg::TagBits'(block_number_i);
    end
  end

  // Compare against every valid slot
  always_comb begin
    for (int i = 0; i < lbsp_pkg::SlotCount; i++) begin
      match_vec[i] = slot_valid_q[i] && (slot_tag_q[i] == req_tag_q);
    end
  end

  // Pick the lowest matching slot
  always_comb begin
    any_hit  = 1'b0;
    hit_slot = '0;
    for (int i = lbsp_pkg::SlotCount - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        any_hit  = 1'b1;
        hit_slot = lbsp_pkg::SlotIdxW'(i);
      end
    end
  end

  lbsp_recency u_recency (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .promote_i  (promote),
    .lru_slot_o (lru_slot)
  );

  // Choose the slot and the eviction on a miss
  always_comb begin
    sel_slot      = any_hit ? hit_slot : lru_slot;
    ev_valid      = !any_hit && slot_valid_q[lru_slot];
    ev_tag        = ev_valid ? slot_tag_q[lru_slot] : '0;
    promote.valid = req_valid_q;
    promote.slot  = sel_slot;
    slot_valid_d  = slot_valid_q;
    if (req_valid_q && !any_hit) begin
      slot_valid_d[lru_slot] = 1'b1;
    end
  end

  // Update valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else begin
      slot_valid_q <= slot_valid_d;
    end
  end

  // Reload the tag of the replaced slot
  always_ff @(posedge clk_i) begin
    if (req_valid_q && !any_hit) begin
      slot_tag_q[lru_slot] <= req_tag_q;
    end
  end

  // Register the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      hit_q      <= any_hit;
      slot_q     <= sel_slot;
      ev_valid_q <= ev_valid;
      ev_tag_q   <= ev_tag;
    end
  end

  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign slot_index_o    = lbsp_pkg::SlotOutW'(slot_q);
  assign evicted_valid_o = ev_valid_q;
  assign evicted_block_o = lbsp_pkg::BlockW'(ev_tag_q);

  // Every accepted word gives exactly one result, after the input and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("result strobe missing after accepted word");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(req_valid_q))
    else $error("result strobe without a request");

  // A hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> (!evicted_valid_o && (evicted_block_o == '0)))
    else $error("eviction reported on a hit");

  // Tags are unique among valid slots
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q |-> $onehot0(match_vec))
    else $error("several slots match one tag");

  // Valid bits are never cleared once set
  a_valid_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q |=> ((slot_valid_q & $past(slot_valid_q)) == $past(slot_valid_q)))
    else $error("slot valid bit dropped");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the LRU buffer slot pool: directed and random lookups.
`timescale 1ns / 1ps

module tb_top;

  // One expected lookup result
  typedef struct packed {
    logic        hit;
    logic [3:0]  slot;
    logic        ev_valid;
    logic [15:0] ev_block;
  } lookup_t;

  localparam int RandomWords = 1030;
  localparam int DrainCycles = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic [15:0] block_number_i = '0;
  logic        busy;
  logic        done_o;
  logic        hit_o;
  logic [3:0]  slot_index_o;
  logic        evicted_valid_o;
  logic [15:0] evicted_block_o;

  lru_buffer_slot_pool dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .block_number_i (block_number_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .slot_index_o   (slot_index_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_block_o(evicted_block_o)
  );

  // Shadow copy of the pool: tags, valid bits, order from least to most recent
  lbsp_pkg::tag_t      pool_tag   [lbsp_pkg::SlotCount];
  logic                pool_valid [lbsp_pkg::SlotCount];
  lbsp_pkg::slot_idx_t age_order  [lbsp_pkg::SlotCount];

  logic [15:0] pending_words[$];
  lookup_t     expected_lookups[$];
  int          total_words = 0;
  int          accepted_words = 0;
  int          error_count = 0;
  int          burst_left = 1;
  int          gap_left = 0;

  always #1 clk_i = ~clk_i;

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("ERROR %0t ns: %s got %h expected %h", $time, what, got, want);
    error_count++;
  endtask

  // Move the slot at order position pos to the most recent end
  function automatic void move_to_newest(int pos);
    lbsp_pkg::slot_idx_t s;
    s = age_order[pos];
    for (int i = pos; i < lbsp_pkg::SlotCount - 1; i++) age_order[i] = age_order[i + 1];
    age_order[lbsp_pkg::SlotCount - 1] = s;
  endfunction

  // Look up one block in the shadow pool, update it, return the expected result
  function automatic lookup_t predict_lookup(logic [15:0] blk);
    lbsp_pkg::tag_t tag;
    int             slot;
    int             pos;
    lookup_t        res;
    tag  = lbsp_pkg::tag_t'(blk);
    slot = -1;
    pos  = 0;
    res  = '0;
    // only valid slots match; take the lowest one
    for (int i = 0; i < lbsp_pkg::SlotCount; i++) begin
      if (slot < 0 && pool_valid[i] && pool_tag[i] == tag) slot = i;
    end
    if (slot >= 0) begin
      res.hit = 1'b1;
      for (int i = 0; i < lbsp_pkg::SlotCount; i++) begin
        if (age_order[i] == slot) pos = i;
      end
    end else begin
      // reload the least recent slot
      slot = age_order[0];
      if (pool_valid[slot]) begin
        res.ev_valid = 1'b1;
        res.ev_block = 16'(pool_tag[slot]);
      end
      pool_tag[slot]   = tag;
      pool_valid[slot] = 1'b1;
    end
    move_to_newest(pos);
    res.slot = 4'(slot);
    return res;
  endfunction

  // Driver: present words in bursts with random gaps, predict on acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_lookups.insert(expected_lookups.size(), predict_lookup(block_number_i));
        accepted_words++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_words.size() != 0) begin
          start          <= 1'b1;
          block_number_i <= pending_words.pop_front();
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result strobe against the oldest expectation
  always @(posedge clk_i) begin
    lookup_t want;
    if (rst_ni && done_o !== 1'b0) begin
      if (expected_lookups.size() == 0) begin
        report_mismatch("unexpected result strobe", 16'(done_o), '0);
      end else begin
        want = expected_lookups.pop_front();
        if (hit_o !== want.hit) report_mismatch("hit", 16'(hit_o), 16'(want.hit));
        if (slot_index_o !== want.slot)
          report_mismatch("slot_index", 16'(slot_index_o), 16'(want.slot));
        if (evicted_valid_o !== want.ev_valid)
          report_mismatch("evicted_valid", 16'(evicted_valid_o), 16'(want.ev_valid));
        if (evicted_block_o !== want.ev_block)
          report_mismatch("evicted_block", evicted_block_o, want.ev_block);
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [15:0] working_set[$];
    int          ws_size;
    int          ws_left;
    for (int i = 0; i < lbsp_pkg::SlotCount; i++) begin
      pool_tag[i]   = '0;
      pool_valid[i] = 1'b0;
      age_order[i]  = lbsp_pkg::slot_idx_t'(i);
    end

    // Zero request on invalid zero tags must miss, then hit; fill all slots,
    // hit the least recent slot, evict valid blocks, hit the second newest
    pending_words = '{16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'h0002, 16'h8000,
                      16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0,
                      16'h1234, 16'h7FFF, 16'h8001, 16'h0100, 16'h4000, 16'h0000,
                      16'hBEEF, 16'hFFFF, 16'hBEEF, 16'h0001};

    // Mostly draw from a working set near the pool size, the rest fully random
    ws_left = 0;
    for (int n = 0; n < RandomWords; n++) begin
      if (ws_left == 0) begin
        working_set.delete();
        ws_size = $urandom_range(8, 24);
        repeat (ws_size) working_set.insert(working_set.size(), 16'($urandom));
        ws_left = $urandom_range(64, 200);
      end
      ws_left--;
      if ($urandom_range(0, 3) != 0)
        pending_words.insert(pending_words.size(),
                             working_set[$urandom_range(0, working_set.size() - 1)]);
      else
        pending_words.insert(pending_words.size(), 16'($urandom));
    end
    total_words = pending_words.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hold until every word is accepted and answered, then drain
    do @(negedge clk_i);
    while (accepted_words != total_words || expected_lookups.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);

    if (error_count == 0 && expected_lookups.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
